FILE: rtl/core/ltc_pkg.sv
// shared types and mode codes for the live timestamp catch-up unit
package ltc_pkg;

  localparam int unsigned FIELD_WIDTH = 64;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_ADJUST   = 2'd0;
  localparam mode_t MODE_ARM      = 2'd1;
  localparam mode_t MODE_ARM_AT   = 2'd2;
  localparam mode_t MODE_COMMIT   = 2'd3;

  typedef logic        [FIELD_WIDTH-1:0] epoch_t;
  typedef logic signed [FIELD_WIDTH-1:0] stamp_t;

  typedef struct packed {
    mode_t  mode;
    epoch_t epoch_tag;
    stamp_t start_time;
    stamp_t stop_time;
    stamp_t target_start;
  } in_item_t;

  typedef struct packed {
    stamp_t out_start;
    stamp_t out_stop;
    stamp_t offset_now;
    logic   rebased;
    logic   adjusted;
  } out_item_t;

  // result handoff from the core to the output register
  typedef struct packed {
    logic      load;
    out_item_t item;
  } handoff_t;

endpackage

FILE: rtl/core/ltc_in_if.sv
// request channel carrying one timestamp event
interface ltc_in_if;
  logic               valid;
  logic               ready;
  ltc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ltc_out_if.sv
// result channel carrying one adjusted frame
interface ltc_out_if;
  logic               valid;
  logic               ready;
  ltc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ltc_in_stage.sv
// input register holding one accepted request
module ltc_in_stage (
  input  logic               clk,
  input  logic               rst,
  ltc_in_if.sink             items,
  input  logic               advance,
  output logic               stg_vld,
  output ltc_pkg::in_item_t  stg_item
);

  assign items.ready = !stg_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else if (items.ready) begin
      stg_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      stg_item <= items.data;
    end
  end

endmodule

FILE: rtl/core/ltc_core.sv
// kept offset state and single-pass event logic
module ltc_core #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               stg_vld,
  input  ltc_pkg::in_item_t  stg_item,
  input  logic               out_free,
  output logic               advance,
  output ltc_pkg::handoff_t  handoff
);

  logic [ltc_pkg::FIELD_WIDTH-1:0] epoch_id;
  logic                            rebase_pending;
  logic                            last_stop_valid;
  logic [TIME_WIDTH-1:0]           last_stop;
  logic [TIME_WIDTH-1:0]           time_offset;
  logic                            target_valid;
  logic [TIME_WIDTH-1:0]           target_time;

  logic                  new_epoch;
  logic                  cur_pending;
  logic                  cur_lsv;
  logic [TIME_WIDTH-1:0] cur_ls;
  logic [TIME_WIDTH-1:0] cur_off;
  logic                  cur_tv;
  logic [TIME_WIDTH-1:0] cur_tt;

  logic [TIME_WIDTH-1:0] s_in;
  logic [TIME_WIDTH-1:0] p_in;
  logic [TIME_WIDTH-1:0] r_in;
  logic                  apply;
  logic [TIME_WIDTH-1:0] anchor;
  logic [TIME_WIDTH-1:0] off_use;
  logic [TIME_WIDTH-1:0] o_start;
  logic [TIME_WIDTH-1:0] o_stop;
  logic [TIME_WIDTH-1:0] clamped;
  logic                  is_adjust;

  logic                  rebase_pending_next;
  logic                  last_stop_valid_next;
  logic [TIME_WIDTH-1:0] last_stop_next;
  logic [TIME_WIDTH-1:0] time_offset_next;
  logic                  target_valid_next;
  logic [TIME_WIDTH-1:0] target_time_next;

  // a new epoch sees cleared state
  assign new_epoch   = stg_item.epoch_tag != epoch_id;
  assign cur_pending = !new_epoch && rebase_pending;
  assign cur_lsv     = !new_epoch && last_stop_valid;
  assign cur_ls      = new_epoch ? '0 : last_stop;
  assign cur_off     = new_epoch ? '0 : time_offset;
  assign cur_tv      = !new_epoch && target_valid;
  assign cur_tt      = new_epoch ? '0 : target_time;

  assign s_in = stg_item.start_time[TIME_WIDTH-1:0];
  assign p_in = stg_item.stop_time[TIME_WIDTH-1:0];
  assign r_in = stg_item.target_start[TIME_WIDTH-1:0];

  // rebase puts start on the anchor: new offset is anchor minus raw start
  assign apply   = cur_pending && (cur_tv || cur_lsv);
  assign anchor  = cur_tv ? cur_tt : cur_ls;
  assign off_use = apply ? (anchor - s_in) : cur_off;
  assign o_start = s_in + off_use;
  assign o_stop  = p_in + off_use;

  assign clamped = (cur_lsv && ($signed(cur_ls) > $signed(r_in))) ? cur_ls : r_in;

  assign is_adjust = stg_item.mode == ltc_pkg::MODE_ADJUST;
  assign advance   = stg_vld && (!is_adjust || out_free);

  always_comb begin
    rebase_pending_next  = cur_pending;
    last_stop_valid_next = cur_lsv;
    last_stop_next       = cur_ls;
    time_offset_next     = cur_off;
    target_valid_next    = cur_tv;
    target_time_next     = cur_tt;
    unique case (stg_item.mode)
      ltc_pkg::MODE_ADJUST: begin
        time_offset_next = off_use;
        if (apply) begin
          rebase_pending_next = 1'b0;
          target_valid_next   = 1'b0;
          target_time_next    = '0;
        end
      end
      ltc_pkg::MODE_ARM: begin
        rebase_pending_next = 1'b1;
        target_valid_next   = 1'b0;
        target_time_next    = '0;
      end
      ltc_pkg::MODE_ARM_AT: begin
        rebase_pending_next = 1'b1;
        target_valid_next   = 1'b1;
        target_time_next    = clamped;
      end
      ltc_pkg::MODE_COMMIT: begin
        last_stop_next       = p_in;
        last_stop_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_id        <= '0;
      rebase_pending  <= 1'b0;
      last_stop_valid <= 1'b0;
      last_stop       <= '0;
      time_offset     <= '0;
      target_valid    <= 1'b0;
      target_time     <= '0;
    end else if (advance) begin
      epoch_id        <= stg_item.epoch_tag;
      rebase_pending  <= rebase_pending_next;
      last_stop_valid <= last_stop_valid_next;
      last_stop       <= last_stop_next;
      time_offset     <= time_offset_next;
      target_valid    <= target_valid_next;
      target_time     <= target_time_next;
    end
  end

  // sign-extend the TIME_WIDTH results onto the 64-bit fields
  always_comb begin
    handoff.load            = advance && is_adjust;
    handoff.item.out_start  = ltc_pkg::stamp_t'($signed(o_start));
    handoff.item.out_stop   = ltc_pkg::stamp_t'($signed(o_stop));
    handoff.item.offset_now = ltc_pkg::stamp_t'($signed(off_use));
    handoff.item.rebased    = apply;
    handoff.item.adjusted   = off_use != '0;
  end

endmodule

FILE: rtl/core/ltc_out_stage.sv
// result register toward the consumer
module ltc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  ltc_pkg::handoff_t  handoff,
  output logic               out_free,
  ltc_out_if.source          results
);

  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (handoff.load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff.load) begin
      results.data <= handoff.item;
    end
  end

endmodule

FILE: rtl/core/live_timestamp_catchup_unit.sv
// top level of the live timestamp catch-up unit
//
// Rebases frame start/stop timestamps by a kept offset so a live stream can
// catch up after a pause. Each request carries a mode and an epoch tag; a new
// epoch clears all kept state before the request acts. Arm and arm-at requests
// set a pending rebase (arm-at with a target clamped up to the last committed
// stop), commit records a delivered stop, and adjust returns start and stop
// plus the offset, first moving the offset onto the anchor when a rebase is
// pending and an anchor (target or committed stop) is kept. Only adjust
// requests produce a result. The unit takes one request per cycle unless
// stalled: a request is held in the input register, is processed in a single
// pass against the kept state, and its result is loaded into the output
// register when it advances. The input only stalls while an adjust request
// waits behind a result that the consumer has not taken. Timestamps are
// computed at TIME_WIDTH bits (32 to 64) with wrap-around and are
// sign-extended on the 64-bit result fields.
module live_timestamp_catchup_unit #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  ltc_in_if.sink     items,
  ltc_out_if.source  results
);

  // input register state
  logic               stg_vld;
  ltc_pkg::in_item_t  stg_item;

  // flow control between the stages
  logic               advance;
  logic               out_free;
  ltc_pkg::handoff_t  handoff;

  // input register; it frees up whenever the core consumes its request
  ltc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .advance  (advance),
    .stg_vld  (stg_vld),
    .stg_item (stg_item)
  );

  // kept state and the single-pass event logic
  ltc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .stg_vld  (stg_vld),
    .stg_item (stg_item),
    .out_free (out_free),
    .advance  (advance),
    .handoff  (handoff)
  );

  // result register; non-adjust requests pass by without touching it
  ltc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .handoff  (handoff),
    .out_free (out_free),
    .results  (results)
  );

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");

  // only an adjust request may load a result
  a_load_adjust: assert property (@(posedge clk) disable iff (rst)
    handoff.load |-> (stg_vld && stg_item.mode == ltc_pkg::MODE_ADJUST))
    else $error("result loaded by a non-adjust request");

  // the input only stalls behind a held adjust request and a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (stg_vld && results.valid && !results.ready))
    else $error("input stalled without a full result register");

  // a loaded result shows up as valid in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    handoff.load |=> results.valid)
    else $error("loaded result not presented");

endmodule
